>>> hw/rtl/ucrs_pkg.sv
// Shared types and constants for the unit-cube ray slab intersection block.
`timescale 1ns / 1ps
`default_nettype none
package ucrs_pkg;

  // Coordinate word width and default fraction bits (Q16.16)
  localparam int COORD_W = 32;
  localparam int FRAC_W = 16;

  // Parallel threshold register
  localparam int THR_W = 17;
  localparam logic [THR_W-1:0] THR_RESET = 17'd7;

  // Number of axes, one lane each
  localparam int NUM_AXES = 3;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic signed [COORD_W-1:0] dir_x;
    logic signed [COORD_W-1:0] dir_y;
    logic signed [COORD_W-1:0] dir_z;
  } ucrs_req_t;

  typedef struct packed {
    logic                      hit;
    logic signed [COORD_W-1:0] t_near;
    logic signed [COORD_W-1:0] t_far;
  } ucrs_res_t;

  // Per-distance control carried alongside the divider
  typedef struct packed {
    logic par;   // direction counts as parallel
    logic nneg;  // numerator negative
    logic qneg;  // quotient negative
    logic ovf;   // quotient magnitude needs more than COORD_W bits
  } ucrs_side_t;

endpackage
`default_nettype wire

>>> hw/rtl/ucrs_div_step.sv
// One restoring-division step: produces one quotient bit per clock.
`timescale 1ns / 1ps
`default_nettype none
module ucrs_div_step
  import ucrs_pkg::*;
#(
  parameter int W = COORD_W
) (
  input  wire logic         clk_i,
  input  wire logic [W-1:0] r_i,
  input  wire logic [W-1:0] x_i,
  input  wire logic [W-1:0] q_i,
  input  wire logic [W-1:0] d_i,
  output logic      [W-1:0] r_o,
  output logic      [W-1:0] x_o,
  output logic      [W-1:0] q_o,
  output logic      [W-1:0] d_o
);

  logic [W:0]   rs;
  logic [W:0]   diff;
  logic         ge;
  logic [W-1:0] r_d;

  // shift in next dividend bit, trial subtract
  always_comb begin
    rs   = {r_i, x_i[W-1]};
    diff = rs - {1'b0, d_i};
    ge   = (rs >= {1'b0, d_i});
    r_d  = ge ? diff[W-1:0] : rs[W-1:0];
  end

  always_ff @(posedge clk_i) begin
    r_o <= r_d;
    x_o <= {x_i[W-2:0], 1'b0};
    q_o <= {q_i[W-2:0], ge};
    d_o <= d_i;
  end

endmodule
`default_nettype wire

>>> hw/rtl/ucrs_lane.sv
// One axis lane: numerators, pipelined dividers, saturation and ordering.
`timescale 1ns / 1ps
`default_nettype none
module ucrs_lane
  import ucrs_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_W
) (
  input  wire logic                      clk_i,
  input  wire logic signed [COORD_W-1:0] o_i,
  input  wire logic signed [COORD_W-1:0] d_i,
  input  wire logic        [THR_W-1:0]   thr_i,
  output logic signed      [COORD_W-1:0] lo_o,
  output logic signed      [COORD_W-1:0] hi_o
);

  localparam int W = COORD_W;
  localparam logic [W-1:0] QMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] QMIN = {1'b1, {(W-1){1'b0}}};

  // prep
  logic               dneg;
  logic [W-1:0]       dmag;
  logic               par;
  logic signed [W+1:0] one_s;
  logic signed [W+1:0] os;
  logic signed [W+1:0] nv   [2];
  logic [W+1:0]       nabs [2];
  logic [W:0]         nmag [2];
  logic [W:0]         top  [2];
  ucrs_side_t         side_d [2];

  // divider chain, index 0 is the prep register
  logic [W-1:0] r_p [2][W+1];
  logic [W-1:0] x_p [2][W+1];
  logic [W-1:0] q_p [2][W+1];
  logic [W-1:0] d_p [2][W+1];
  ucrs_side_t   side_p [2][W+1];

  // post
  logic [W-1:0]        mag [2];
  logic [W-1:0]        lim [2];
  logic [W-1:0]        m   [2];
  logic signed [W-1:0] v   [2];

  // numerators (-1 - o) and (1 - o), direction magnitude, parallel test
  always_comb begin
    dneg  = d_i[W-1];
    dmag  = dneg ? (~d_i + 1'b1) : d_i;
    par   = (dmag == '0) || ({{(W-THR_W){1'b0}}, thr_i} > dmag);
    one_s = (W+2)'(1) << FRAC_BITS;
    os    = {{2{o_i[W-1]}}, o_i};
    nv[0] = -one_s - os;
    nv[1] = one_s - os;
    for (int b = 0; b < 2; b++) begin
      nabs[b] = nv[b][W+1] ? (~nv[b] + 1'b1) : nv[b];
      nmag[b] = nabs[b][W:0];
      top[b]  = nmag[b] >> (W - FRAC_BITS);
      side_d[b].par  = par;
      side_d[b].nneg = nv[b][W+1];
      side_d[b].qneg = nv[b][W+1] ^ dneg;
      side_d[b].ovf  = (top[b] >= {1'b0, dmag});
    end
  end

  for (genvar b = 0; b < 2; b++) begin : g_prep
    always_ff @(posedge clk_i) begin
      r_p[b][0]    <= top[b][W-1:0];
      x_p[b][0]    <= W'({nmag[b], {FRAC_BITS{1'b0}}});
      q_p[b][0]    <= '0;
      d_p[b][0]    <= dmag;
      side_p[b][0] <= side_d[b];
    end
  end

  // one quotient bit per stage
  for (genvar b = 0; b < 2; b++) begin : g_div
    for (genvar k = 0; k < W; k++) begin : g_step
      ucrs_div_step #(.W(W)) u_step (
        .clk_i (clk_i),
        .r_i   (r_p[b][k]),
        .x_i   (x_p[b][k]),
        .q_i   (q_p[b][k]),
        .d_i   (d_p[b][k]),
        .r_o   (r_p[b][k+1]),
        .x_o   (x_p[b][k+1]),
        .q_o   (q_p[b][k+1]),
        .d_o   (d_p[b][k+1])
      );
      always_ff @(posedge clk_i) begin
        side_p[b][k+1] <= side_p[b][k];
      end
    end
  end

  // saturate, sign, parallel override
  always_comb begin
    for (int b = 0; b < 2; b++) begin
      mag[b] = side_p[b][W].ovf ? {W{1'b1}} : q_p[b][W];
      lim[b] = side_p[b][W].qneg ? QMIN : QMAX;
      m[b]   = (mag[b] > lim[b]) ? lim[b] : mag[b];
      v[b]   = side_p[b][W].qneg ? $signed(~m[b] + 1'b1) : $signed(m[b]);
      if (side_p[b][W].par) begin
        v[b] = side_p[b][W].nneg ? $signed(QMIN) : $signed(QMAX);
      end
    end
  end

  // order the pair
  always_ff @(posedge clk_i) begin
    if (v[0] > v[1]) begin
      lo_o <= v[1];
      hi_o <= v[0];
    end else begin
      lo_o <= v[0];
      hi_o <= v[1];
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/ucrs_merge.sv
// Merge of the axis lanes: largest entry, smallest exit, hit flag.
`timescale 1ns / 1ps
`default_nettype none
module ucrs_merge
  import ucrs_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic signed [COORD_W-1:0] lo_i [NUM_AXES],
  input  wire logic signed [COORD_W-1:0] hi_i [NUM_AXES],
  output ucrs_res_t                      res_o
);

  logic signed [COORD_W-1:0] near_d, far_d;
  logic signed [COORD_W-1:0] near_q, far_q;

  // max of entries, min of exits
  always_comb begin
    near_d = lo_i[0];
    far_d  = hi_i[0];
    for (int a = 1; a < NUM_AXES; a++) begin
      if (lo_i[a] > near_d) near_d = lo_i[a];
      if (hi_i[a] < far_d)  far_d  = hi_i[a];
    end
  end

  always_ff @(posedge clk_i) begin
    near_q <= near_d;
    far_q  <= far_d;
  end

  // hit test, output register
  always_ff @(posedge clk_i) begin
    res_o.hit    <= (near_q <= far_q);
    res_o.t_near <= near_q;
    res_o.t_far  <= far_q;
  end

endmodule
`default_nettype wire

>>> hw/rtl/unit_cube_ray_slab_intersect.sv
// Top level of the unit-cube ray slab intersection block.
`timescale 1ns / 1ps
`default_nettype none
// Ray versus the cube [-1,1]^3 by the slab method, signed fixed point.
// A request is taken whenever start is high; busy is always low, so one ray
// can enter every cycle. The result is on result_o with result_valid_o high
// for one cycle; the request passes the input register, then each of the
// three axis lanes runs a prep register and two pipelined restoring
// dividers that resolve one quotient bit per stage, followed by saturation,
// ordering and a two-stage merge. Coordinates are Q16.16 at the default
// FRAC_BITS. The receiver cannot stall the result. The threshold register
// may be written only while no request is in flight.
module unit_cube_ray_slab_intersect
  import ucrs_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_W
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire ucrs_req_t        req_i,
  input  wire logic             cfg_we_i,
  input  wire logic [THR_W-1:0] cfg_wdata_i,
  output ucrs_res_t             result_o,
  output logic                  result_valid_o
);

  localparam int LAT = COORD_W + 5;

  logic                      accept;
  ucrs_req_t                 req_q;
  logic [THR_W-1:0]          thr_q;
  logic [LAT-1:0]            vld_q;
  logic signed [COORD_W-1:0] o_l  [NUM_AXES];
  logic signed [COORD_W-1:0] d_l  [NUM_AXES];
  logic signed [COORD_W-1:0] lo_l [NUM_AXES];
  logic signed [COORD_W-1:0] hi_l [NUM_AXES];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
  end

  // valid pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], accept};
    end
  end

  assign o_l[0] = req_q.origin_x;
  assign o_l[1] = req_q.origin_y;
  assign o_l[2] = req_q.origin_z;
  assign d_l[0] = req_q.dir_x;
  assign d_l[1] = req_q.dir_y;
  assign d_l[2] = req_q.dir_z;

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    ucrs_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk_i (clk_i),
      .o_i   (o_l[a]),
      .d_i   (d_l[a]),
      .thr_i (thr_q),
      .lo_o  (lo_l[a]),
      .hi_o  (hi_l[a])
    );
  end

  ucrs_merge u_merge (
    .clk_i (clk_i),
    .lo_i  (lo_l),
    .hi_i  (hi_l),
    .res_o (result_o)
  );

  assign result_valid_o = vld_q[LAT-1];

  // assertions
  a_accept_tracked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> vld_q[0])
    else $error("accepted request not tracked");

  a_hit_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.hit) |-> (result_o.t_near <= result_o.t_far))
    else $error("hit with near beyond far");

  a_miss_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.hit) |-> (result_o.t_near > result_o.t_far))
    else $error("miss with near not beyond far");

endmodule
`default_nettype wire
